>>> sv/tridiagonal_sweep_solver_core_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the sweep solver core
// ---------------------------------------------------------------------------
`ifndef TRIDIAGONAL_SWEEP_SOLVER_CORE_MACROS_SVH
`define TRIDIAGONAL_SWEEP_SOLVER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define TSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define TSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TSS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/tss_pkg.sv
// ---------------------------------------------------------------------------
// tss_pkg
// types and constants shared by the sweep solver core
// ---------------------------------------------------------------------------
package tss_pkg;
    typedef struct packed {
        logic signed [31:0] sub_diag;
        logic signed [31:0] main_diag;
        logic signed [31:0] super_diag;
        logic signed [31:0] rhs_value;
        logic               last_row;
    } t_row_in;

    typedef struct packed {
        logic signed [31:0] solution_value;
        logic [5:0]         row_index;
        logic               last_result;
        logic [1:0]         status;
    } t_sol_out;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_PIV = 2'd1;
    localparam logic [1:0] ST_TOO_FEW  = 2'd2;
    localparam logic [1:0] ST_TOO_MANY = 2'd3;

    // divider request and reply
    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction
endpackage

>>> sv/tss_divider.sv
// ---------------------------------------------------------------------------
// tss_divider
// radix-2 restoring divider, (num << FRAC) / den truncated and saturated
// ---------------------------------------------------------------------------
module tss_divider import tss_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int QW = 64 + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] r_quo, n_quo;
    logic [63:0]   r_dvs, n_dvs;
    logic [64:0]   r_rem, n_rem;
    logic          r_neg, n_neg;
    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;
    logic [64:0]   w_sh;
    logic [QW:0]   w_sq;

    always_comb begin
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        w_sh   = {r_rem[63:0], r_quo[QW-1]};
        if (i_req.start) begin
            n_quo  = {(i_req.num[63] ? 64'(-i_req.num) : 64'(i_req.num)),
                      {FRAC_BITS{1'b0}}};
            n_dvs  = i_req.den[63] ? 64'(-i_req.den) : 64'(i_req.den);
            n_rem  = '0;
            n_neg  = i_req.num[63] ^ i_req.den[63];
            n_busy = 1'b1;
            n_cnt  = CW'(QW);
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_dvs}) begin
                n_rem = w_sh - {1'b0, r_dvs};
                n_quo = {r_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[QW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
        r_neg <= n_neg;
    end

    always_comb begin
        w_sq = r_neg ? (QW+1)'(-{1'b0, r_quo}) : {1'b0, r_quo};
        o_rsp.done = r_done;
        if (!r_neg && r_quo > QW'(32'h7fffffff)) begin
            o_rsp.quo = 32'sh7fffffff;
        end else if (r_neg && r_quo > QW'(33'h080000000)) begin
            o_rsp.quo = 32'sh80000000;
        end else begin
            o_rsp.quo = w_sq[31:0];
        end
    end
endmodule

>>> sv/tridiagonal_sweep_solver_core.sv
// ---------------------------------------------------------------------------
// tridiagonal_sweep_solver_core
// Thomas algorithm solver in fixed point with v/u row memories
// ---------------------------------------------------------------------------
// Input channel: one row per transaction (i_row_valid/o_row_stall). Rows of a
// system arrive in order; last_row closes the system.
// Output channel: solution transactions (o_sol_valid/i_sol_stall), from index
// n-1 down to 0; last_result marks index 0. An errored system gives one
// result with its status and last_result set.
// After a row is taken the input stalls while the sequencer works through
// it in S_RD, S_DEN, S_MULU, S_DIVU, S_DIVV and S_END; the serial divider
// runs twice per row (u then v). A last row skips the v division.
// Back substitution reads the two memories and uses one multiplier: each
// solution passes S_BRD (S_BWAIT after the first), S_BMUL and S_BOUT.
// The input stalls during the row work and the whole back substitution.
// Reset clears the row count, error code, output valid flag and the
// sequencer; memory contents stay undefined, and a value read before it is
// written is not used.
// A stalled solution holds in the output register; new results wait for it.
// ---------------------------------------------------------------------------
`include "tridiagonal_sweep_solver_core_macros.svh"
module tridiagonal_sweep_solver_core import tss_pkg::*; #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_row_valid,
    output logic     o_row_stall,
    input  t_row_in  i_row,
    output logic     o_sol_valid,
    input  logic     i_sol_stall,
    output t_sol_out o_sol
);
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNTW = 7;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_DEN   = 4'd2;
    localparam logic [3:0] S_MULU  = 4'd3;
    localparam logic [3:0] S_DIVU  = 4'd4;
    localparam logic [3:0] S_DIVV  = 4'd5;
    localparam logic [3:0] S_END   = 4'd6;
    localparam logic [3:0] S_BRD   = 4'd7;
    localparam logic [3:0] S_BMUL  = 4'd8;
    localparam logic [3:0] S_BOUT  = 4'd9;
    localparam logic [3:0] S_BWAIT = 4'd10;

    logic [31:0] r_vmem [MAX_ROWS];
    logic [31:0] r_umem [MAX_ROWS];
    logic [31:0] r_vrd, r_urd;

    logic [3:0]      r_st, n_st;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [1:0]      r_err, n_err;
    t_row_in         r_row, n_row;
    logic signed [63:0] r_den, n_den;
    logic signed [63:0] r_prod, n_prod;
    logic signed [31:0] r_x, n_x;
    logic [AW-1:0]   r_bi, n_bi;
    logic            r_bfirst, n_bfirst;
    logic            r_ov, n_ov;
    t_sol_out        r_out, n_out;

    logic            w_we_v, w_we_u;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [31:0]     w_wv, w_wu;
    t_div_req        w_req;
    t_div_rsp        w_rsp;
    logic signed [63:0] w_mul;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_fl;
    logic            w_acc;
    logic [CNTW-1:0] w_n;
    logic [1:0]      w_fst;

    tss_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (w_we_v) begin
            r_vmem[w_waddr] <= w_wv;
        end
        if (w_we_u) begin
            r_umem[w_waddr] <= w_wu;
        end
        r_vrd <= r_vmem[w_raddr];
        r_urd <= r_umem[w_raddr];
    end

    assign w_mul = w_ma * w_mb;
    assign w_fl  = r_prod >>> FRAC_BITS;
    assign w_acc = i_row_valid && !o_row_stall;
    assign o_row_stall = (r_st != S_IDLE);
    assign o_sol_valid = r_ov;
    assign o_sol = r_out;
    assign w_n = r_cnt;

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_err = r_err; n_row = r_row;
        n_den = r_den; n_prod = r_prod; n_x = r_x; n_bi = r_bi;
        n_bfirst = r_bfirst; n_ov = r_ov; n_out = r_out;
        w_we_v = 1'b0; w_we_u = 1'b0;
        w_waddr = r_cnt[AW-1:0]; w_wv = '0; w_wu = '0;
        w_raddr = r_cnt[AW-1:0] - 1'b1;
        w_req = '0;
        w_ma = r_row.sub_diag; w_mb = $signed(r_vrd);
        w_fst = r_err;
        if (r_ov && !i_sol_stall) begin
            n_ov = 1'b0;
        end
        case (r_st)
            S_IDLE: begin
                if (w_acc) begin
                    n_row = i_row;
                    n_st = S_RD;
                end
            end
            S_RD: begin
                // read v/u of the previous row
                if (r_err != ST_OK) begin
                    n_st = S_END;
                end else if (r_cnt >= CNTW'(MAX_ROWS)) begin
                    n_err = ST_TOO_MANY;
                    n_st = S_END;
                end else begin
                    n_st = S_DEN;
                end
            end
            S_DEN: begin
                if (r_cnt == '0) begin
                    n_prod = '0;
                end else begin
                    n_prod = w_mul;
                end
                n_st = S_MULU;
            end
            S_MULU: begin
                n_den = -64'(r_row.main_diag) - w_fl;
                if (-64'(r_row.main_diag) - w_fl == 64'sd0) begin
                    n_err = ST_ZERO_PIV;
                    n_st = S_END;
                end else begin
                    w_mb = $signed(r_urd);
                    n_prod = (r_cnt == '0) ? 64'sd0 : w_mul;
                    n_st = S_DIVU;
                    n_bfirst = 1'b1;
                end
            end
            S_DIVU: begin
                if (r_bfirst) begin
                    w_req.start = 1'b1;
                    w_req.num = w_fl - 64'(r_row.rhs_value);
                    w_req.den = r_den;
                    n_bfirst = 1'b0;
                end else if (w_rsp.done) begin
                    w_we_u = 1'b1;
                    w_wu = w_rsp.quo;
                    n_st = S_DIVV;
                    n_bfirst = 1'b1;
                end
            end
            S_DIVV: begin
                if (r_row.last_row) begin
                    w_we_v = 1'b1;
                    w_wv = '0;
                    n_st = S_END;
                end else if (r_bfirst) begin
                    w_req.start = 1'b1;
                    w_req.num = 64'(r_row.super_diag);
                    w_req.den = r_den;
                    n_bfirst = 1'b0;
                end else if (w_rsp.done) begin
                    w_we_v = 1'b1;
                    w_wv = w_rsp.quo;
                    n_st = S_END;
                end
            end
            S_END: begin
                if (r_cnt <= CNTW'(MAX_ROWS)) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (!r_row.last_row) begin
                    n_st = S_IDLE;
                end else begin
                    w_fst = r_err;
                    if (r_err == ST_OK && r_cnt == '0) begin
                        w_fst = ST_TOO_FEW;
                    end
                    if (w_fst != ST_OK) begin
                        if (!r_ov || !i_sol_stall) begin
                            n_ov = 1'b1;
                            n_out.solution_value = '0;
                            n_out.row_index = '0;
                            n_out.last_result = 1'b1;
                            n_out.status = w_fst;
                            n_cnt = '0;
                            n_err = ST_OK;
                            n_st = S_IDLE;
                        end else begin
                            n_cnt = r_cnt;
                        end
                    end else begin
                        n_bi = r_cnt[AW-1:0];
                        n_bfirst = 1'b1;
                        n_st = S_BRD;
                    end
                end
            end
            S_BRD: begin
                w_raddr = r_bi;
                n_st = S_BMUL;
            end
            S_BMUL: begin
                w_raddr = r_bi;
                w_ma = $signed(r_vrd);
                w_mb = r_x;
                n_prod = w_mul;
                n_st = S_BOUT;
            end
            S_BOUT: begin
                w_raddr = r_bi;
                if (!r_ov || !i_sol_stall) begin
                    n_x = r_bfirst ? $signed(r_urd)
                        : sat32(66'(w_fl) + 66'($signed(r_urd)));
                    n_ov = 1'b1;
                    n_out.solution_value = n_x;
                    n_out.row_index = 6'(r_bi);
                    n_out.last_result = (r_bi == '0);
                    n_out.status = ST_OK;
                    n_bfirst = 1'b0;
                    if (r_bi == '0) begin
                        n_cnt = '0;
                        n_err = ST_OK;
                        n_st = S_IDLE;
                    end else begin
                        n_bi = r_bi - 1'b1;
                        n_st = S_BWAIT;
                    end
                end
            end
            S_BWAIT: begin
                w_raddr = r_bi;
                n_st = S_BMUL;
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_err <= ST_OK;
            r_ov <= 1'b0;
            r_bfirst <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_err <= n_err;
            r_ov <= n_ov;
            r_bfirst <= n_bfirst;
        end
        r_row <= n_row;
        r_den <= n_den;
        r_prod <= n_prod;
        r_x <= n_x;
        r_bi <= n_bi;
        r_out <= n_out;
    end

    `TSS_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_st != S_IDLE, !w_acc)
    `TSS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, w_n <= CNTW'(MAX_ROWS + 1))
    `TSS_ASSERT_NXT(a_err_out_last, i_clk, i_rst_n, o_sol_valid && !i_sol_stall && o_sol.status != ST_OK, !o_sol_valid)
    `TSS_ASSERT_IMP(a_err_shape, i_clk, i_rst_n, o_sol_valid && o_sol.status != ST_OK, o_sol.last_result && o_sol.row_index == '0)
endmodule

>>> verif/tb_tridiagonal_sweep_solver_core.sv
// ---------------------------------------------------------------------------
// tb_tridiagonal_sweep_solver_core
// Feeds tridiagonal systems row by row through the valid/stall channel and
// checks every solution transaction against a fixed point Thomas sweep kept
// in the bench, with random gaps on the input and random stalls on the output
// ---------------------------------------------------------------------------
module tb_tridiagonal_sweep_solver_core import tss_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 16;
    localparam longint CYCLE_LIMIT = 20000000;

    class sweep_scoreboard;
        logic signed [31:0] ratio_mem [MAX_ROWS];
        logic signed [31:0] offset_mem[MAX_ROWS];
        int unsigned rows_held;
        logic [1:0]  first_err;
        t_sol_out    pending_sol[$];
        int unsigned fails;

        function new();
            rows_held = 0;
            first_err = ST_OK;
            fails = 0;
        endfunction

        static function logic signed [31:0] clip32(input longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        // floor shift of the full product
        static function longint fx_mul(input longint p, input longint q);
            longint m;
            m = p * q;
            return m >>> FRAC_BITS;
        endfunction

        static function logic signed [31:0] fx_quot(input longint num, input longint den);
            logic signed [79:0] n;
            logic signed [79:0] q;
            n = 80'(num) <<< FRAC_BITS;
            q = n / 80'(den);
            if (q > 80'sd2147483647) return 32'sh7fffffff;
            if (q < -80'sd2147483648) return 32'sh80000000;
            return q[31:0];
        endfunction

        function void add_expected(input t_sol_out s);
            pending_sol = {pending_sol, s};
        endfunction

        function void note_row(input t_row_in r);
            longint a, vp, up, den;
            int unsigned n;
            logic [1:0] st;
            logic signed [31:0] x;
            t_sol_out s;
            if (first_err == ST_OK) begin
                if (rows_held >= MAX_ROWS) begin
                    first_err = ST_TOO_MANY;
                end else begin
                    a = 0; vp = 0; up = 0;
                    if (rows_held > 0) begin
                        vp = ratio_mem[rows_held-1];
                        up = offset_mem[rows_held-1];
                        a  = r.sub_diag;
                    end
                    den = -longint'(r.main_diag) - fx_mul(a, vp);
                    if (den == 0) begin
                        first_err = ST_ZERO_PIV;
                    end else begin
                        offset_mem[rows_held] = fx_quot(fx_mul(a, up) - longint'(r.rhs_value), den);
                        ratio_mem[rows_held] = r.last_row ? 32'sd0
                                             : fx_quot(longint'(r.super_diag), den);
                    end
                end
            end
            if (rows_held <= MAX_ROWS) rows_held++;
            if (!r.last_row) return;
            n = rows_held;
            st = first_err;
            if (st == ST_OK && n < 2) st = ST_TOO_FEW;
            rows_held = 0;
            first_err = ST_OK;
            if (st != ST_OK) begin
                s = '{solution_value: 0, row_index: 0, last_result: 1'b1, status: st};
                add_expected(s);
                return;
            end
            x = offset_mem[n-1];
            s = '{solution_value: x, row_index: 6'(n-1), last_result: 1'b0, status: ST_OK};
            add_expected(s);
            for (int i = n - 1; i > 0; i--) begin
                x = clip32(fx_mul(ratio_mem[i-1], x) + longint'(offset_mem[i-1]));
                s = '{solution_value: x, row_index: 6'(i-1), last_result: 1'(i == 1),
                      status: ST_OK};
                add_expected(s);
            end
        endfunction

        function void check_sol(input t_sol_out got);
            t_sol_out exp_s;
            if (pending_sol.size() == 0) begin
                $error("unexpected solution transaction %p", got);
                fails++;
                return;
            end
            exp_s = pending_sol.pop_front();
            if (got.solution_value !== exp_s.solution_value) begin
                $error("solution_value exp %0d got %0d", exp_s.solution_value, got.solution_value);
                fails++;
            end
            if (got.row_index !== exp_s.row_index) begin
                $error("row_index exp %0d got %0d", exp_s.row_index, got.row_index);
                fails++;
            end
            if (got.last_result !== exp_s.last_result) begin
                $error("last_result exp %0d got %0d", exp_s.last_result, got.last_result);
                fails++;
            end
            if (got.status !== exp_s.status) begin
                $error("status exp %0d got %0d", exp_s.status, got.status);
                fails++;
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_row_valid;
    logic     o_row_stall;
    t_row_in  i_row;
    logic     o_sol_valid;
    logic     i_sol_stall;
    t_sol_out o_sol;

    sweep_scoreboard sb;
    longint cycles = 0;

    tridiagonal_sweep_solver_core #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) dut (.*);

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic signed [31:0] rand_coef(input int big);
        if (big != 0 || $urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endfunction

    // receiver side: random stall, checks each accepted transaction
    initial begin
        i_sol_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_sol_valid && !i_sol_stall) sb.check_sol(o_sol);
            if ($urandom_range(0, 199) == 0) begin
                i_sol_stall <= 1'b1;
                repeat ($urandom_range(20, 100)) begin
                    @(posedge i_clk);
                    if (o_sol_valid && !i_sol_stall) sb.check_sol(o_sol);
                end
                i_sol_stall <= 1'b0;
            end else begin
                i_sol_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
            end
        end
    end

    task automatic send_row(input t_row_in r);
        int g;
        i_row_valid <= 1'b1;
        i_row <= r;
        @(posedge i_clk);
        while (o_row_stall) @(posedge i_clk);
        sb.note_row(r);
        g = gap_len();
        if (g > 0) begin
            i_row_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_system(input int nrows, input int dominant, input int big);
        t_row_in r;
        for (int k = 0; k < nrows; k++) begin
            r.sub_diag   = rand_coef(big);
            r.super_diag = rand_coef(big);
            r.rhs_value  = rand_coef(big);
            r.main_diag  = rand_coef(big);
            if (dominant != 0 && big == 0)
                r.main_diag = ($urandom_range(0, 1) ? 1 : -1) * $signed($urandom_range(32'h0004_0000, 32'h0010_0000));
            r.last_row = (k == nrows - 1);
            send_row(r);
        end
    endtask

    task automatic wait_drained();
        i_row_valid <= 1'b0;
        while (sb.pending_sol.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        t_row_in r;
        int sent;
        sb = new();
        i_rst_n = 1'b0;
        i_row_valid = 1'b0;
        i_row = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single row system
        r = '{sub_diag: 0, main_diag: 32'sh0001_0000, super_diag: 0, rhs_value: 5, last_row: 1};
        send_row(r);
        // zero pivot on the first row, then one more row of that system
        r = '{sub_diag: 32'sh7fffffff, main_diag: 0, super_diag: 32'sh80000000,
              rhs_value: 32'sh7fffffff, last_row: 0};
        send_row(r);
        r.main_diag = 32'sh0002_0000; r.last_row = 1;
        send_row(r);
        // zero pivot on a later row: b = -a*v_prev
        r = '{sub_diag: 0, main_diag: 32'shffff_0000, super_diag: 32'sh0001_0000,
              rhs_value: 0, last_row: 0};
        send_row(r);
        r = '{sub_diag: 32'sh0001_0000, main_diag: 32'shffff_0000, super_diag: 0,
              rhs_value: 32'sh80000000, last_row: 1};
        send_row(r);
        // extremes, saturating quotients
        r = '{sub_diag: 32'sh80000000, main_diag: 1, super_diag: 32'sh7fffffff,
              rhs_value: 32'sh80000000, last_row: 0};
        send_row(r);
        r = '{sub_diag: 32'sh7fffffff, main_diag: 32'sh80000000, super_diag: 32'sh80000000,
              rhs_value: 32'sh7fffffff, last_row: 0};
        send_row(r);
        r = '{sub_diag: 32'shffffffff, main_diag: 32'sh7fffffff, super_diag: 32'shffffffff,
              rhs_value: 32'shffffffff, last_row: 1};
        send_row(r);
        send_system(2, 1, 0);
        send_system(5, 1, 0);
        // wait for all results before going on
        wait_drained();
        // the largest system, then one too long
        send_system(MAX_ROWS, 1, 0);
        send_system(MAX_ROWS + 2, 1, 0);

        sent = 0;
        while (sent < 150) begin
            int n, p;
            p = $urandom_range(0, 99);
            if (p < 70) n = $urandom_range(2, 8);
            else if (p < 85) n = 1;
            else if (p < 95) n = $urandom_range(9, 30);
            else n = $urandom_range(60, 66);
            send_system(n, ($urandom_range(0, 9) < 8), ($urandom_range(0, 9) == 0));
            sent += n;
            if ($urandom_range(0, 29) == 0) wait_drained();
        end
        wait_drained();
        if (sb.fails == 0 && sb.pending_sol.size() == 0) begin
            $display("tb_tridiagonal_sweep_solver_core: PASS");
        end else begin
            $display("tb_tridiagonal_sweep_solver_core: FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_tridiagonal_sweep_solver_core: FAIL");
            $finish;
        end
    end
endmodule

>>> tridiagonal_sweep_solver_core.f
+incdir+sv
sv/tss_pkg.sv
sv/tss_divider.sv
sv/tridiagonal_sweep_solver_core.sv
verif/tb_tridiagonal_sweep_solver_core.sv
